/* rtl/q2e_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: shared package
// Widths of the rotation terms and CORDIC datapath, status flags carried
// down the pipeline and the arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

   // rotation-matrix terms: |T| < 2^33 for 16-bit components
   localparam int TERM_W   = 35;
   // CORDIC x/y lanes, room for the gain of about 1.65
   localparam int CORDIC_W = 38;
   // angle accumulator, 30 fraction bits
   localparam int ZACC_W   = 34;
   localparam int ACC_FRAC = 30;
   localparam int ATAN_TAB_LEN = 24;
   // pitch, yaw and roll lanes
   localparam int NUM_LANES = 3;
   localparam int LANE_PITCH = 0;
   localparam int LANE_YAW   = 1;
   localparam int LANE_ROLL  = 2;

   // signs of the divisors and numerators, for the quadrant fix-up
   typedef struct packed {
      logic t22_zero;
      logic t22_neg;
      logic t21_pos;
      logic t21_neg;
      logic t00_zero;
      logic t00_neg;
      logic t10_pos;
      logic t10_neg;
   } flags_type;

   // atan(2^-i) * 2^30, truncated
   function automatic logic [30:0] atan_tab(input int idx);
      logic [30:0] v;
      case (idx)
         0:  v = 31'd843314856;
         1:  v = 31'd497837829;
         2:  v = 31'd263043836;
         3:  v = 31'd133525158;
         4:  v = 31'd67021686;
         5:  v = 31'd33543515;
         6:  v = 31'd16775850;
         7:  v = 31'd8388437;
         8:  v = 31'd4194282;
         9:  v = 31'd2097149;
         10: v = 31'd1048575;
         11: v = 31'd524287;
         12: v = 31'd262143;
         13: v = 31'd131071;
         14: v = 31'd65535;
         15: v = 31'd32767;
         16: v = 31'd16383;
         17: v = 31'd8191;
         18: v = 31'd4095;
         19: v = 31'd2047;
         20: v = 31'd1023;
         21: v = 31'd511;
         22: v = 31'd255;
         23: v = 31'd127;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/q2e_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion request channel
// Valid/ready channel carrying one quaternion in Q2.14.
// ----------------------------------------------------------------------------
interface q2e_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;

   modport source (output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
   modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                   input quat_z, output ready);
endinterface
`default_nettype wire

/* rtl/q2e_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Euler angle response channel
// Valid/ready channel carrying pitch, yaw and roll in Q3.13 radians.
// ----------------------------------------------------------------------------
interface q2e_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch;
   logic signed [15:0] yaw;
   logic signed [15:0] roll;

   modport source (output valid, output pitch, output yaw, output roll,
                   input ready);
   modport sink   (input valid, input pitch, input yaw, input roll,
                   output ready);
endinterface
`default_nettype wire

/* rtl/q2e_terms.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotation term front end
// Four stages: component products, matrix terms, sign folding and arcsine
// argument clamp, then 1 - s^2 for the square root.
// ----------------------------------------------------------------------------
module q2e_terms #(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire logic signed [15:0]                     quat_w,
   input  wire logic signed [15:0]                     quat_x,
   input  wire logic signed [15:0]                     quat_y,
   input  wire logic signed [15:0]                     quat_z,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic signed [q2e_pkg::TERM_W-1:0]           p_x,
   output logic signed [q2e_pkg::TERM_W-1:0]           p_y,
   output logic signed [q2e_pkg::TERM_W-1:0]           r_x,
   output logic signed [q2e_pkg::TERM_W-1:0]           r_y,
   output logic signed [2*QUAT_FRAC_BITS+1:0]          s_out,
   output logic        [4*QUAT_FRAC_BITS+1:0]          v_out,
   output q2e_pkg::flags_type                          flags_out
);

   localparam int TW = q2e_pkg::TERM_W;
   localparam int SW = 2*QUAT_FRAC_BITS + 2;
   localparam int VW = 4*QUAT_FRAC_BITS + 2;
   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << (2*QUAT_FRAC_BITS));
   localparam logic [VW-1:0] ONE_SQ = VW'(64'd1 << (4*QUAT_FRAC_BITS));

   // stage valids and enables
   logic [3:0] v_ff;
   logic [4:0] en;

   assign en[4] = out_ready;
   assign en[3] = ~v_ff[3] | en[4];
   assign en[2] = ~v_ff[2] | en[3];
   assign en[1] = ~v_ff[1] | en[2];
   assign en[0] = ~v_ff[0] | en[1];
   assign in_ready  = en[0];
   assign out_valid = v_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
         if (en[3]) v_ff[3] <= v_ff[2];
      end
   end

   // stage 1: the ten products
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ww_ff <= quat_w * quat_w;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         xy_ff <= quat_x * quat_y;
         wz_ff <= quat_w * quat_z;
         xz_ff <= quat_x * quat_z;
         wy_ff <= quat_w * quat_y;
         yz_ff <= quat_y * quat_z;
         wx_ff <= quat_w * quat_x;
      end
   end

   // stage 2: matrix terms
   logic signed [TW-1:0] t00_ff, t10_ff, t20_ff, t21_ff, t22_ff;
   logic signed [TW-1:0] t00_in, t10_in, t20_in, t21_in, t22_in;

   always_comb begin
      t00_in = TW'(ww_ff) + TW'(xx_ff) - TW'(yy_ff) - TW'(zz_ff);
      t22_in = TW'(ww_ff) - TW'(xx_ff) - TW'(yy_ff) + TW'(zz_ff);
      t10_in = (TW'(xy_ff) + TW'(wz_ff)) <<< 1;
      t20_in = (TW'(xz_ff) - TW'(wy_ff)) <<< 1;
      t21_in = (TW'(yz_ff) + TW'(wx_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t00_ff <= t00_in;
         t10_ff <= t10_in;
         t20_ff <= t20_in;
         t21_ff <= t21_in;
         t22_ff <= t22_in;
      end
   end

   // stage 3: fold to a positive divisor, clamp the arcsine argument
   logic signed [TW-1:0] px_ff, py_ff, rx_ff, ry_ff;
   logic signed [SW-1:0] s3_ff;
   logic        [SW-2:0] mag_ff;
   q2e_pkg::flags_type   fl3_ff;
   logic signed [TW-1:0] s_neg, s_sat, s_abs;
   q2e_pkg::flags_type   fl_in;

   always_comb begin
      fl_in.t22_zero = (t22_ff == '0);
      fl_in.t22_neg  = t22_ff[TW-1];
      fl_in.t21_pos  = ~t21_ff[TW-1] & (t21_ff != '0);
      fl_in.t21_neg  = t21_ff[TW-1];
      fl_in.t00_zero = (t00_ff == '0);
      fl_in.t00_neg  = t00_ff[TW-1];
      fl_in.t10_pos  = ~t10_ff[TW-1] & (t10_ff != '0);
      fl_in.t10_neg  = t10_ff[TW-1];
      s_neg = -t20_ff;
      if (s_neg > ONE_T) begin
         s_sat = ONE_T;
      end else if (s_neg < -ONE_T) begin
         s_sat = -ONE_T;
      end else begin
         s_sat = s_neg;
      end
      s_abs = s_sat[TW-1] ? -s_sat : s_sat;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         px_ff  <= t22_ff[TW-1] ? -t22_ff : t22_ff;
         py_ff  <= t22_ff[TW-1] ? -t21_ff : t21_ff;
         rx_ff  <= t00_ff[TW-1] ? -t00_ff : t00_ff;
         ry_ff  <= t00_ff[TW-1] ? -t10_ff : t10_ff;
         s3_ff  <= s_sat[SW-1:0];
         mag_ff <= s_abs[SW-2:0];
         fl3_ff <= fl_in;
      end
   end

   // stage 4: 1 - s^2 in 4*QF fraction bits
   logic [VW-1:0] sq;

   assign sq = VW'(mag_ff) * VW'(mag_ff);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         p_x       <= px_ff;
         p_y       <= py_ff;
         r_x       <= rx_ff;
         r_y       <= ry_ff;
         s_out     <= s3_ff;
         v_out     <= ONE_SQ - sq;
         flags_out <= fl3_ff;
      end
   end

endmodule
`default_nettype wire

/* rtl/q2e_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root, one result bit per stage, with a sideband that
// travels alongside.
// ----------------------------------------------------------------------------
module q2e_isqrt #(
   parameter int VAL_W  = 58,
   parameter int SIDE_W = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [VAL_W-1:0]       val_in,
   input  wire logic [SIDE_W-1:0]      side_in,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [VAL_W/2-1:0]          root_out,
   output logic [SIDE_W-1:0]           side_out
);

   localparam int RT_W = VAL_W / 2;
   localparam int IW   = VAL_W + 1;

   logic [RT_W-1:0]   v_ff;
   logic [RT_W:0]     en;
   logic [IW-1:0]     rem_ff  [RT_W];
   logic [IW-1:0]     res_ff  [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];
   logic [IW-1:0]     rem_in  [RT_W];
   logic [IW-1:0]     res_in  [RT_W];

   // stall chain: a stage moves when it is empty or the next one moves
   assign en[RT_W] = out_ready;
   genvar g;
   generate
      for (g = 0; g < RT_W; g++) begin : gen_en
         assign en[g] = ~v_ff[g] | en[g+1];
      end
   endgenerate
   assign in_ready  = en[0];
   assign out_valid = v_ff[RT_W-1];
   assign root_out  = res_ff[RT_W-1][RT_W-1:0];
   assign side_out  = side_ff[RT_W-1];

   // one trial subtraction per stage
   always_comb begin
      logic [IW-1:0] rem_p;
      logic [IW-1:0] res_p;
      logic [IW-1:0] bit_k;
      logic [IW-1:0] trial;
      for (int k = 0; k < RT_W; k++) begin
         if (k == 0) begin
            rem_p = IW'(val_in);
            res_p = '0;
         end else begin
            rem_p = rem_ff[k-1];
            res_p = res_ff[k-1];
         end
         bit_k = IW'(1) << (VAL_W - 2 - 2*k);
         trial = res_p + bit_k;
         if (rem_p >= trial) begin
            rem_in[k] = rem_p - trial;
            res_in[k] = (res_p >> 1) + bit_k;
         end else begin
            rem_in[k] = rem_p;
            res_in[k] = res_p >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < RT_W; k++) begin
            if (en[k]) v_ff[k] <= (k == 0) ? in_valid : v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RT_W; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            res_ff[k]  <= res_in[k];
            side_ff[k] <= (k == 0) ? side_in : side_ff[k-1];
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/q2e_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-lane vectoring CORDIC
// One micro-rotation per stage on each lane; the angle accumulator ends as
// atan(y/x) with 30 fraction bits.
// ----------------------------------------------------------------------------
module q2e_cordic #(
   parameter int STAGES = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic                                                   clock,
   input  wire logic                                                   reset,
   input  wire logic                                                   in_valid,
   output logic                                                        in_ready,
   input  wire logic [q2e_pkg::NUM_LANES-1:0][q2e_pkg::CORDIC_W-1:0]   x_in,
   input  wire logic [q2e_pkg::NUM_LANES-1:0][q2e_pkg::CORDIC_W-1:0]   y_in,
   input  wire logic [SIDE_W-1:0]                                      side_in,
   output logic                                                        out_valid,
   input  wire logic                                                   out_ready,
   output logic [q2e_pkg::NUM_LANES-1:0][q2e_pkg::ZACC_W-1:0]          z_out,
   output logic [SIDE_W-1:0]                                           side_out
);

   localparam int CW = q2e_pkg::CORDIC_W;
   localparam int ZW = q2e_pkg::ZACC_W;
   localparam int NL = q2e_pkg::NUM_LANES;

   logic [STAGES-1:0]    v_ff;
   logic [STAGES:0]      en;
   logic signed [CW-1:0] x_ff [STAGES][NL];
   logic signed [CW-1:0] y_ff [STAGES][NL];
   logic signed [ZW-1:0] z_ff [STAGES][NL];
   logic [SIDE_W-1:0]    side_ff [STAGES];
   logic signed [CW-1:0] x_in_s [STAGES][NL];
   logic signed [CW-1:0] y_in_s [STAGES][NL];
   logic signed [ZW-1:0] z_in_s [STAGES][NL];

   assign en[STAGES] = out_ready;
   genvar g;
   generate
      for (g = 0; g < STAGES; g++) begin : gen_en
         assign en[g] = ~v_ff[g] | en[g+1];
      end
      for (g = 0; g < NL; g++) begin : gen_out
         assign z_out[g] = z_ff[STAGES-1][g];
      end
   endgenerate
   assign in_ready  = en[0];
   assign out_valid = v_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

   // micro-rotations, driven towards y = 0
   always_comb begin
      logic signed [CW-1:0] xp, yp, dx, dy;
      logic signed [ZW-1:0] zp, tz;
      for (int k = 0; k < STAGES; k++) begin
         for (int l = 0; l < NL; l++) begin
            if (k == 0) begin
               xp = $signed(x_in[l]);
               yp = $signed(y_in[l]);
               zp = '0;
            end else begin
               xp = x_ff[k-1][l];
               yp = y_ff[k-1][l];
               zp = z_ff[k-1][l];
            end
            dx = yp >>> k;
            dy = xp >>> k;
            tz = $signed({{(ZW-31){1'b0}}, q2e_pkg::atan_tab(k)});
            if (!yp[CW-1]) begin
               x_in_s[k][l] = xp + dx;
               y_in_s[k][l] = yp - dy;
               z_in_s[k][l] = zp + tz;
            end else begin
               x_in_s[k][l] = xp - dx;
               y_in_s[k][l] = yp + dy;
               z_in_s[k][l] = zp - tz;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= (k == 0) ? in_valid : v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= (k == 0) ? side_in : side_ff[k-1];
            for (int l = 0; l < NL; l++) begin
               x_ff[k][l] <= x_in_s[k][l];
               y_ff[k][l] <= y_in_s[k][l];
               z_ff[k][l] <= z_in_s[k][l];
            end
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quaternion to Euler angles
// Pipelined conversion of a Q2.14 quaternion to pitch, yaw and roll.
// ----------------------------------------------------------------------------
// Takes one quaternion per clock while the pipeline is not stalled and returns
// one (pitch, yaw, roll) triple per quaternion, in order, in Q3.13 radians
// (ANGLE_FRAC_BITS fraction bits). The pipeline is four front-end stages
// forming the matrix terms, one square-root stage per result bit for the
// arcsine cosine, one stage per CORDIC micro-rotation and the output
// register. Every stage has its own valid bit and fills bubbles
// independently, so input keeps flowing into empty stages while a result
// waits at the output. Pitch and roll come from atan of the matrix term
// ratios, yaw from asin(-T20); a zero divisor gives +/-pi/2 and the pi
// quadrant corrections use pi = 3.1416. Angles saturate to 16 bits.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
   parameter int QUAT_FRAC_BITS  = 14,
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int CORDIC_STAGES   = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   q2e_req_if.sink   req_ch,
   q2e_rsp_if.source rsp_ch
);

   localparam int TW = q2e_pkg::TERM_W;
   localparam int CW = q2e_pkg::CORDIC_W;
   localparam int ZW = q2e_pkg::ZACC_W;
   localparam int SW = 2*QUAT_FRAC_BITS + 2;
   localparam int VW = 4*QUAT_FRAC_BITS + 2;
   localparam int RW = VW / 2;
   localparam int FW = $bits(q2e_pkg::flags_type);
   localparam int SIDE1_W = 4*TW + SW + FW;
   localparam int AW = 20;
   localparam int PI_I   = (31416 * (1 << ANGLE_FRAC_BITS) + 5000) / 10000;
   localparam int HALF_I = (15708 * (1 << ANGLE_FRAC_BITS) + 5000) / 10000;
   localparam logic signed [AW-1:0] PI_U   = AW'(PI_I);
   localparam logic signed [AW-1:0] HALF_U = AW'(HALF_I);
   localparam logic signed [ZW-1:0] RND =
      ZW'(64'd1 << (q2e_pkg::ACC_FRAC - 1 - ANGLE_FRAC_BITS));
   localparam int SHR = q2e_pkg::ACC_FRAC - ANGLE_FRAC_BITS;

   // front end
   logic                 fe_valid, fe_ready;
   logic signed [TW-1:0] fe_px, fe_py, fe_rx, fe_ry;
   logic signed [SW-1:0] fe_s;
   logic [VW-1:0]        fe_v;
   q2e_pkg::flags_type   fe_flags;

   q2e_terms #(
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .quat_w    (req_ch.quat_w),
      .quat_x    (req_ch.quat_x),
      .quat_y    (req_ch.quat_y),
      .quat_z    (req_ch.quat_z),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .p_x       (fe_px),
      .p_y       (fe_py),
      .r_x       (fe_rx),
      .r_y       (fe_ry),
      .s_out     (fe_s),
      .v_out     (fe_v),
      .flags_out (fe_flags)
   );

   // square root of 1 - s^2, other operands ride alongside
   logic               sq_valid, sq_ready;
   logic [RW-1:0]      sq_root;
   logic [SIDE1_W-1:0] sq_side_in, sq_side;

   assign sq_side_in = {fe_flags, fe_s, fe_rx, fe_ry, fe_px, fe_py};

   q2e_isqrt #(
      .VAL_W  (VW),
      .SIDE_W (SIDE1_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .val_in    (fe_v),
      .side_in   (sq_side_in),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   // unpack and widen the CORDIC operands
   logic signed [TW-1:0] u_py, u_px, u_ry, u_rx;
   logic signed [SW-1:0] u_s;
   q2e_pkg::flags_type   u_flags;
   logic [q2e_pkg::NUM_LANES-1:0][CW-1:0] cx, cy;

   assign u_py    = sq_side[TW-1:0];
   assign u_px    = sq_side[2*TW-1:TW];
   assign u_ry    = sq_side[3*TW-1:2*TW];
   assign u_rx    = sq_side[4*TW-1:3*TW];
   assign u_s     = sq_side[4*TW+SW-1:4*TW];
   assign u_flags = q2e_pkg::flags_type'(sq_side[SIDE1_W-1:4*TW+SW]);

   always_comb begin
      cx[q2e_pkg::LANE_PITCH] = {{(CW-TW){u_px[TW-1]}}, u_px};
      cy[q2e_pkg::LANE_PITCH] = {{(CW-TW){u_py[TW-1]}}, u_py};
      cx[q2e_pkg::LANE_YAW]   = {{(CW-RW){1'b0}}, sq_root};
      cy[q2e_pkg::LANE_YAW]   = {{(CW-SW){u_s[SW-1]}}, u_s};
      cx[q2e_pkg::LANE_ROLL]  = {{(CW-TW){u_rx[TW-1]}}, u_rx};
      cy[q2e_pkg::LANE_ROLL]  = {{(CW-TW){u_ry[TW-1]}}, u_ry};
   end

   logic               cor_valid, en_out;
   logic [q2e_pkg::NUM_LANES-1:0][ZW-1:0] cor_z;
   logic [FW-1:0]      cor_side;
   q2e_pkg::flags_type cor_flags;

   q2e_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (FW)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .x_in      (cx),
      .y_in      (cy),
      .side_in   (u_flags),
      .out_valid (cor_valid),
      .out_ready (en_out),
      .z_out     (cor_z),
      .side_out  (cor_side)
   );

   assign cor_flags = q2e_pkg::flags_type'(cor_side);

   // clamp to the 16-bit output range
   function automatic logic [15:0] sat16(input logic signed [AW-1:0] v);
      logic [15:0] r;
      if (v > AW'(32767)) begin
         r = 16'h7FFF;
      end else if (v < -AW'(32768)) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // rounding, zero-divisor cases and pi corrections
   logic signed [ZW-1:0] zr_p, zr_y, zr_r;
   logic signed [AW-1:0] a_p, a_y, a_r, pitch_c, yaw_c, roll_c;

   always_comb begin
      zr_p = ($signed(cor_z[q2e_pkg::LANE_PITCH]) + RND) >>> SHR;
      zr_y = ($signed(cor_z[q2e_pkg::LANE_YAW])   + RND) >>> SHR;
      zr_r = ($signed(cor_z[q2e_pkg::LANE_ROLL])  + RND) >>> SHR;
      a_p  = zr_p[AW-1:0];
      a_y  = zr_y[AW-1:0];
      a_r  = zr_r[AW-1:0];

      if (cor_flags.t22_zero) begin
         pitch_c = cor_flags.t21_pos ? HALF_U : (cor_flags.t21_neg ? -HALF_U : '0);
      end else begin
         pitch_c = a_p;
      end

      if (cor_flags.t22_neg) begin
         yaw_c = a_y[AW-1] ? (a_y + PI_U) : (a_y - PI_U);
      end else begin
         yaw_c = a_y;
      end

      if (cor_flags.t00_zero) begin
         roll_c = cor_flags.t10_pos ? HALF_U : (cor_flags.t10_neg ? -HALF_U : '0);
      end else begin
         roll_c = a_r;
      end
      if (cor_flags.t00_neg) begin
         roll_c = cor_flags.t10_pos ? (roll_c + PI_U) : (roll_c - PI_U);
      end
   end

   // output register
   logic        out_valid_ff;
   logic [15:0] pitch_ff, yaw_ff, roll_ff;

   assign en_out = ~out_valid_ff | rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         pitch_ff <= sat16(pitch_c);
         yaw_ff   <= sat16(yaw_c);
         roll_ff  <= sat16(roll_c);
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.pitch = pitch_ff;
   assign rsp_ch.yaw   = yaw_ff;
   assign rsp_ch.roll  = roll_ff;

   // zero divisor with a positive numerator gives +pi/2 pitch
   a_pitch_half: assert property (@(posedge clock) disable iff (reset)
      (en_out && cor_valid && cor_flags.t22_zero && cor_flags.t21_pos)
      |=> (rsp_ch.pitch == 16'(HALF_I)))
      else $error("pitch not +pi/2 for zero divisor");

   // a zero divisor never carries the negative flag
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      (cor_valid && (cor_flags.t22_zero || cor_flags.t00_zero))
      |-> !((cor_flags.t22_zero && cor_flags.t22_neg) ||
            (cor_flags.t00_zero && cor_flags.t00_neg)))
      else $error("divisor flags inconsistent");

   // 0/0 for roll gives a zero angle
   a_roll_zero: assert property (@(posedge clock) disable iff (reset)
      (en_out && cor_valid && cor_flags.t00_zero && !cor_flags.t10_pos &&
       !cor_flags.t10_neg)
      |=> (rsp_ch.roll == 16'sd0))
      else $error("roll not zero for 0/0");

endmodule
`default_nettype wire
